>>> design/hlc_pkg.sv
// Shared types and constants of the homogeneous line clipper.
`default_nettype none
package hlc_pkg;

    localparam int unsigned NCOORD    = 4;
    localparam int unsigned NLANE     = 6;
    localparam int unsigned T_FRAC    = 30;
    localparam int unsigned T_W       = 31;
    localparam int unsigned DIV_STEPS = 31;
    localparam int unsigned CRD_W     = 32;
    localparam int unsigned EPS_W     = 16;
    localparam logic [T_W-1:0] T_ONE  = 31'h4000_0000;
    localparam logic [15:0] EPS_RESET = 16'd1;

    // One plane during division and the interval update
    typedef struct packed {
        logic [34:0] rem;
        logic [33:0] pm;
        logic [30:0] quot;
        logic        qneg;
        logic        pneg;
        logic        par;
        logic        sat;
    } t_lane;

    typedef t_lane [NLANE-1:0] t_lane_arr;

    // Segment data carried beside the planes
    typedef struct packed {
        logic [NCOORD-1:0][31:0] s;
        logic [NCOORD-1:0][31:0] e;
        logic [NCOORD-1:0][32:0] dm;
        logic [NCOORD-1:0]       dneg;
    } t_seg;

endpackage
`default_nettype wire

>>> design/hlc_div_cell.sv
// One restoring-division step for all six plane ratios.
`default_nettype none
module hlc_div_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire hlc_pkg::t_lane_arr i_lanes,
    input  wire hlc_pkg::t_seg      i_seg,
    output logic                    o_valid,
    output hlc_pkg::t_lane_arr      o_lanes,
    output hlc_pkg::t_seg           o_seg
);

    logic               r_valid;
    hlc_pkg::t_lane_arr r_lanes;
    hlc_pkg::t_seg      r_seg;
    hlc_pkg::t_lane_arr n_lanes;
    logic [hlc_pkg::NLANE-1:0][34:0] diff;
    logic [hlc_pkg::NLANE-1:0][34:0] sel;
    logic [hlc_pkg::NLANE-1:0]       ge;

    // Subtract the divisor where it fits, shift in one quotient bit
    always_comb begin
        n_lanes = i_lanes;
        for (int k = 0; k < hlc_pkg::NLANE; k++) begin
            diff[k] = i_lanes[k].rem - {1'b0, i_lanes[k].pm};
            ge[k]   = i_lanes[k].rem >= {1'b0, i_lanes[k].pm};
            sel[k]  = ge[k] ? diff[k] : i_lanes[k].rem;
            n_lanes[k].rem  = {sel[k][33:0], 1'b0};
            n_lanes[k].quot = {i_lanes[k].quot[29:0], ge[k]};
        end
    end

    // Advance the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_lanes <= n_lanes;
            r_seg   <= i_seg;
        end
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;
    assign o_seg   = r_seg;

endmodule
`default_nettype wire

>>> design/hlc_plane_cell.sv
// One plane of the parametric interval update; consumes the lowest lane.
`default_nettype none
module hlc_plane_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic                        i_ok,
    input  wire logic [hlc_pkg::T_W-1:0]     i_ten,
    input  wire logic [hlc_pkg::T_W-1:0]     i_tex,
    input  wire hlc_pkg::t_lane_arr          i_lanes,
    input  wire hlc_pkg::t_seg               i_seg,
    output logic                             o_valid,
    output logic                             o_ok,
    output logic [hlc_pkg::T_W-1:0]          o_ten,
    output logic [hlc_pkg::T_W-1:0]          o_tex,
    output hlc_pkg::t_lane_arr               o_lanes,
    output hlc_pkg::t_seg                    o_seg
);

    logic                   r_valid;
    logic                   r_ok;
    logic [hlc_pkg::T_W-1:0] r_ten;
    logic [hlc_pkg::T_W-1:0] r_tex;
    hlc_pkg::t_lane_arr     r_lanes;
    hlc_pkg::t_seg          r_seg;
    logic                   n_ok;
    logic [hlc_pkg::T_W-1:0] n_ten;
    logic [hlc_pkg::T_W-1:0] n_tex;
    hlc_pkg::t_lane_arr     n_lanes;
    hlc_pkg::t_lane         ln;
    logic [31:0]            rmag;
    logic signed [32:0]     r;
    logic signed [32:0]     ten_s;
    logic signed [32:0]     tex_s;

    // Narrow the interval against this plane
    always_comb begin
        ln    = i_lanes[0];
        rmag  = ln.sat ? 32'h8000_0000 : {1'b0, ln.quot};
        r     = (ln.qneg != ln.pneg) ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
        ten_s = $signed({2'b00, i_ten});
        tex_s = $signed({2'b00, i_tex});
        n_ok  = i_ok;
        n_ten = i_ten;
        n_tex = i_tex;
        if (i_ok) begin
            if (ln.par) begin
                n_ok = !ln.qneg;
            end else if (ln.pneg) begin
                if (r > tex_s) begin
                    n_ok = 1'b0;
                end else if (r > ten_s) begin
                    n_ten = r[hlc_pkg::T_W-1:0];
                end
            end else begin
                if (r < ten_s) begin
                    n_ok = 1'b0;
                end else if (r < tex_s) begin
                    n_tex = r[hlc_pkg::T_W-1:0];
                end
            end
        end
        // Drop the consumed plane
        n_lanes = i_lanes;
        for (int k = 0; k < hlc_pkg::NLANE - 1; k++) begin
            n_lanes[k] = i_lanes[k+1];
        end
    end

    // Advance the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_ok    <= n_ok;
            r_ten   <= n_ten;
            r_tex   <= n_tex;
            r_lanes <= n_lanes;
            r_seg   <= i_seg;
        end
    end

    assign o_valid = r_valid;
    assign o_ok    = r_ok;
    assign o_ten   = r_ten;
    assign o_tex   = r_tex;
    assign o_lanes = r_lanes;
    assign o_seg   = r_seg;

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_ok |-> r_ten <= r_tex)
        else $error("interval inverted on a surviving segment");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_ok |-> r_tex <= hlc_pkg::T_ONE)
        else $error("exit parameter above one");

endmodule
`default_nettype wire

>>> design/homogeneous_line_clipper_top.sv
// Top level of the homogeneous line clipper: setup, cell chains, interpolation.
// Pipeline from input transfer to result: 2 setup stages, 31 divide cells,
//   6 plane cells, 1 multiply stage, 1 round and output stage.
// Throughput: one segment per cycle when not stalled; each divide cell retires one quotient bit
//   of all six plane ratios, so the chain never loops back.
// A stalled result holds the whole pipeline; input stall follows it directly.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets epsilon to 1.
`default_nettype none
module homogeneous_line_clipper_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_start_x,
    input  wire logic [31:0] i_start_y,
    input  wire logic [31:0] i_start_z,
    input  wire logic [31:0] i_start_w,
    input  wire logic [31:0] i_end_x,
    input  wire logic [31:0] i_end_y,
    input  wire logic [31:0] i_end_z,
    input  wire logic [31:0] i_end_w,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_visible,
    output logic [31:0]      o_clipped_start_x,
    output logic [31:0]      o_clipped_start_y,
    output logic [31:0]      o_clipped_start_z,
    output logic [31:0]      o_clipped_start_w,
    output logic [31:0]      o_clipped_end_x,
    output logic [31:0]      o_clipped_end_y,
    output logic [31:0]      o_clipped_end_z,
    output logic [31:0]      o_clipped_end_w
);

    localparam int unsigned NC = hlc_pkg::NCOORD;
    localparam int unsigned NL = hlc_pkg::NLANE;
    localparam int unsigned ND = hlc_pkg::DIV_STEPS;

    logic        en;
    logic [15:0] r_eps;

    // Pipeline advances unless a finished result is held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Hold the parallel epsilon register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= hlc_pkg::EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    // ---------------- setup stage 1: deltas and plane terms
    logic [NC-1:0][31:0]        in_s;
    logic [NC-1:0][31:0]        in_e;
    logic signed [NC-1:0][32:0] n_p1_d;
    logic signed [NL-1:0][32:0] n_p1_q;
    logic signed [NL-1:0][33:0] n_p1_p;
    logic                       r_p1_valid;
    logic [NC-1:0][31:0]        r_p1_s;
    logic [NC-1:0][31:0]        r_p1_e;
    logic signed [NC-1:0][32:0] r_p1_d;
    logic signed [NL-1:0][32:0] r_p1_q;
    logic signed [NL-1:0][33:0] r_p1_p;
    logic signed [32:0]         sw;
    logic signed [32:0]         sc;
    logic signed [33:0]         dw;
    logic signed [33:0]         dc;

    assign in_s = {i_start_w, i_start_z, i_start_y, i_start_x};
    assign in_e = {i_end_w, i_end_z, i_end_y, i_end_x};

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            n_p1_d[i] = $signed({in_e[i][31], in_e[i]}) - $signed({in_s[i][31], in_s[i]});
        end
        sw = $signed({in_s[3][31], in_s[3]});
        dw = $signed({n_p1_d[3][32], n_p1_d[3]});
        for (int i = 0; i < 3; i++) begin
            sc = $signed({in_s[i][31], in_s[i]});
            dc = $signed({n_p1_d[i][32], n_p1_d[i]});
            n_p1_q[2*i]   = sw - sc;
            n_p1_p[2*i]   = dc - dw;
            n_p1_q[2*i+1] = sw + sc;
            n_p1_p[2*i+1] = -dw - dc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (en) begin
            r_p1_valid <= i_valid;
        end
        if (en) begin
            r_p1_s <= in_s;
            r_p1_e <= in_e;
            r_p1_d <= n_p1_d;
            r_p1_q <= n_p1_q;
            r_p1_p <= n_p1_p;
        end
    end

    // ---------------- setup stage 2: magnitudes, parallel and saturation flags
    hlc_pkg::t_lane_arr n_p2_lanes;
    hlc_pkg::t_seg      n_p2_seg;
    logic [32:0]        qm;
    logic [33:0]        pm;
    logic               r_p2_valid;
    hlc_pkg::t_lane_arr r_p2_lanes;
    hlc_pkg::t_seg      r_p2_seg;

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            qm = r_p1_q[k][32] ? 33'(-r_p1_q[k]) : 33'(r_p1_q[k]);
            pm = r_p1_p[k][33] ? 34'(-r_p1_p[k]) : 34'(r_p1_p[k]);
            n_p2_lanes[k].rem  = {2'b00, qm};
            n_p2_lanes[k].pm   = pm;
            n_p2_lanes[k].quot = '0;
            n_p2_lanes[k].qneg = r_p1_q[k][32];
            n_p2_lanes[k].pneg = r_p1_p[k][33];
            n_p2_lanes[k].par  = (pm == '0) || (pm < {18'd0, r_eps});
            n_p2_lanes[k].sat  = {2'b00, qm} >= {pm, 1'b0};
        end
        for (int i = 0; i < NC; i++) begin
            n_p2_seg.s[i]    = r_p1_s[i];
            n_p2_seg.e[i]    = r_p1_e[i];
            n_p2_seg.dneg[i] = r_p1_d[i][32];
            n_p2_seg.dm[i]   = r_p1_d[i][32] ? 33'(-r_p1_d[i]) : 33'(r_p1_d[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (en) begin
            r_p2_valid <= r_p1_valid;
        end
        if (en) begin
            r_p2_lanes <= n_p2_lanes;
            r_p2_seg   <= n_p2_seg;
        end
    end

    // ---------------- divide chain: one quotient bit per cell
    logic               dv_valid [ND+1];
    hlc_pkg::t_lane_arr dv_lanes [ND+1];
    hlc_pkg::t_seg      dv_seg   [ND+1];

    assign dv_valid[0] = r_p2_valid;
    assign dv_lanes[0] = r_p2_lanes;
    assign dv_seg[0]   = r_p2_seg;

    for (genvar g = 0; g < ND; g++) begin : g_div
        hlc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_valid[g]),
            .i_lanes (dv_lanes[g]),
            .i_seg   (dv_seg[g]),
            .o_valid (dv_valid[g+1]),
            .o_lanes (dv_lanes[g+1]),
            .o_seg   (dv_seg[g+1])
        );
    end

    // ---------------- plane chain: one clip plane per cell
    logic                    pl_valid [NL+1];
    logic                    pl_ok    [NL+1];
    logic [hlc_pkg::T_W-1:0] pl_ten   [NL+1];
    logic [hlc_pkg::T_W-1:0] pl_tex   [NL+1];
    hlc_pkg::t_lane_arr      pl_lanes [NL+1];
    hlc_pkg::t_seg           pl_seg   [NL+1];

    assign pl_valid[0] = dv_valid[ND];
    assign pl_ok[0]    = 1'b1;
    assign pl_ten[0]   = '0;
    assign pl_tex[0]   = hlc_pkg::T_ONE;
    assign pl_lanes[0] = dv_lanes[ND];
    assign pl_seg[0]   = dv_seg[ND];

    for (genvar g = 0; g < NL; g++) begin : g_plane
        hlc_plane_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (pl_valid[g]),
            .i_ok    (pl_ok[g]),
            .i_ten   (pl_ten[g]),
            .i_tex   (pl_tex[g]),
            .i_lanes (pl_lanes[g]),
            .i_seg   (pl_seg[g]),
            .o_valid (pl_valid[g+1]),
            .o_ok    (pl_ok[g+1]),
            .o_ten   (pl_ten[g+1]),
            .o_tex   (pl_tex[g+1]),
            .o_lanes (pl_lanes[g+1]),
            .o_seg   (pl_seg[g+1])
        );
    end

    // ---------------- multiply stage: |d| * t for both end points
    logic                r_m_valid;
    logic                r_m_ok;
    logic                r_m_mv_s;
    logic                r_m_mv_e;
    hlc_pkg::t_seg       r_m_seg;
    logic [NC-1:0][63:0] r_m_ps;
    logic [NC-1:0][63:0] r_m_pe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= pl_valid[NL];
        end
        if (en) begin
            r_m_ok   <= pl_ok[NL];
            r_m_mv_s <= pl_ten[NL] != '0;
            r_m_mv_e <= pl_tex[NL] < hlc_pkg::T_ONE;
            r_m_seg  <= pl_seg[NL];
            for (int i = 0; i < NC; i++) begin
                r_m_ps[i] <= 64'(pl_seg[NL].dm[i]) * 64'(pl_ten[NL]);
                r_m_pe[i] <= 64'(pl_seg[NL].dm[i]) * 64'(pl_tex[NL]);
            end
        end
    end

    // ---------------- round and output stage
    logic [NC-1:0][63:0] rnd_s;
    logic [NC-1:0][63:0] rnd_e;
    logic [NC-1:0][31:0] n_cs;
    logic [NC-1:0][31:0] n_ce;
    logic                r_out_valid;
    logic                r_vis;
    logic [NC-1:0][31:0] r_cs;
    logic [NC-1:0][31:0] r_ce;

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            rnd_s[i] = r_m_ps[i] + (64'd1 << (hlc_pkg::T_FRAC - 1));
            rnd_e[i] = r_m_pe[i] + (64'd1 << (hlc_pkg::T_FRAC - 1));
            if (!r_m_ok) begin
                n_cs[i] = '0;
                n_ce[i] = '0;
            end else begin
                if (r_m_mv_s) begin
                    n_cs[i] = r_m_seg.dneg[i] ? r_m_seg.s[i] - rnd_s[i][61:30]
                                              : r_m_seg.s[i] + rnd_s[i][61:30];
                end else begin
                    n_cs[i] = r_m_seg.s[i];
                end
                if (r_m_mv_e) begin
                    n_ce[i] = r_m_seg.dneg[i] ? r_m_seg.s[i] - rnd_e[i][61:30]
                                              : r_m_seg.s[i] + rnd_e[i][61:30];
                end else begin
                    n_ce[i] = r_m_seg.e[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_m_valid;
        end
        if (en) begin
            r_vis <= r_m_ok;
            r_cs  <= n_cs;
            r_ce  <= n_ce;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_visible         = r_vis;
    assign o_clipped_start_x = r_cs[0];
    assign o_clipped_start_y = r_cs[1];
    assign o_clipped_start_z = r_cs[2];
    assign o_clipped_start_w = r_cs[3];
    assign o_clipped_end_x   = r_ce[0];
    assign o_clipped_end_y   = r_ce[1];
    assign o_clipped_end_z   = r_ce[2];
    assign o_clipped_end_w   = r_ce[3];

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_visible |-> (r_cs == '0) && (r_ce == '0))
        else $error("rejected segment carries nonzero points");
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(r_vis) && $stable(r_cs) && $stable(r_ce))
        else $error("stalled result changed");

endmodule
`default_nettype wire
